// ===== design/afg_pkg.sv =====
// Shared types, constants and helpers for the arming / failsafe / throttle gate.
package afg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = FRAC_BITS;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int ONE_Q      = 1 << FRAC_BITS;
    localparam int MAX_Q      = ONE_Q - 1;
    localparam int DEAD_Q     = (ONE_Q * 5 + 99) / 100;
    localparam int OFF_Q      = (ONE_Q + 999) / 1000;
    localparam int GAIN_Q16   = 69221;
    localparam int GAIN_SHIFT = 16;
    localparam int GAIN_W     = 17;
    localparam int MUL_B_W    = (QW + 1 > GAIN_W) ? QW + 1 : GAIN_W;
    localparam int PROD_W     = QW + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE    = 2'd2;

    localparam logic [CFG_W-1:0] LOCK_MS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] SAFETY_RST  = 16'd6554;
    localparam logic [CFG_W-1:0] IDLE_RST    = 16'd66;

    localparam logic [1:0] MODE_TEST = 2'd0;
    localparam logic [1:0] MODE_OFF  = 2'd1;
    localparam logic [1:0] MODE_MIX  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] lock_ms;
        logic [CFG_W-1:0] safety;
        logic [CFG_W-1:0] idle;
    } cfg_t;

    typedef struct packed {
        logic [3:0]        aux_switches;
        logic              failsafe;
        logic              rx_bound;
        logic              usb_attached;
        logic              usb_motor_test;
        logic              turtle_active;
        logic              reverse_pending;
        logic              override_request;
        logic [TIME_W-1:0] time_ms;
        logic [QW-1:0]     stick_throttle;
        logic [QW-1:0]     curved_throttle;
    } item_t;

    typedef struct packed {
        logic          armed;
        logic          airborne;
        logic          grounded;
        logic          test_override;
        logic          override_active;
        logic [QW-1:0] throttle_out;
        logic [1:0]    motor_mode;
        logic          set_forward;
        logic          lockout;
        logic          throttle_guard;
        logic          arm_guard;
    } res_t;

    function automatic logic [QW-1:0] sat_q(input logic [QW:0] v);
        sat_q = v[QW] ? QW'(MAX_Q) : v[QW-1:0];
    endfunction

endpackage

// ===== design/afg_cfg.sv =====
// Configuration register file: failsafe lock time, safety and idle levels.
module afg_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [afg_pkg::CFG_IDX_W-1:0]  index,
    input  logic [afg_pkg::CFG_W-1:0]      data,
    output afg_pkg::cfg_t                  cfg
);
    import afg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_ms <= LOCK_MS_RST;
            cfg_reg.safety  <= SAFETY_RST;
            cfg_reg.idle    <= IDLE_RST;
        end
        else if (we)
        begin
            unique case (index)
                CFG_LOCK_MS: cfg_reg.lock_ms <= data;
                CFG_SAFETY:  cfg_reg.safety  <= data;
                CFG_IDLE:    cfg_reg.idle    <= data;
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/afg_core.sv =====
// Arming state, failsafe lockout and throttle computation for one tick.
module afg_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  afg_pkg::cfg_t  cfg,
    input  afg_pkg::item_t item,
    output afg_pkg::res_t  res
);
    import afg_pkg::*;

    logic [TIME_W-1:0] fs_start_reg, fs_start_next;
    logic prearm_reg, prearm_next;
    logic arm_sw_reg, arm_sw_next;
    logic thr_guard_reg, thr_guard_next;
    logic arm_guard_reg, arm_guard_next;
    logic armed_reg, armed_next;
    logic air_reg, air_next;
    logic ground_reg, ground_next;
    logic test_reg, test_next;

    logic sw_arm, sw_prearm, sw_idle, sw_test;
    logic ovr, lock, fwd;
    logic [TIME_W-1:0] start_eff, elapsed;
    logic [QW-1:0] thr, curved;
    logic [QW-1:0] mul_a;
    logic [MUL_B_W-1:0] span, mul_b;
    logic [PROD_W-1:0] prod;
    logic [QW:0] gain_rnd, idle_sum;
    logic [QW-1:0] throttle;
    logic [1:0] mode;
    logic thr_over;

    assign sw_arm    = item.aux_switches[0];
    assign sw_prearm = item.aux_switches[1];
    assign sw_idle   = item.aux_switches[2];
    assign sw_test   = item.aux_switches[3];
    assign thr       = item.stick_throttle;
    assign curved    = item.curved_throttle;
    assign thr_over  = thr > cfg.safety;

    assign mul_a = sw_idle ? curved : QW'(curved - QW'(DEAD_Q));
    assign span  = MUL_B_W'(ONE_Q) - MUL_B_W'(cfg.idle);
    assign mul_b = sw_idle ? span : MUL_B_W'(GAIN_Q16);
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign gain_rnd = (QW+1)'((prod + PROD_W'(1 << (GAIN_SHIFT - 1))) >> GAIN_SHIFT);
    assign idle_sum = (QW+1)'(cfg.idle)
                    + (QW+1)'((prod + PROD_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);

    assign start_eff = (fs_start_reg == '0) ? item.time_ms : fs_start_reg;
    assign elapsed   = item.time_ms - start_eff;

    always_comb
    begin
        test_next      = test_reg;
        ground_next    = ground_reg;
        ovr            = item.override_request;
        prearm_next    = prearm_reg;
        arm_sw_next    = arm_sw_reg;
        thr_guard_next = thr_guard_reg;
        arm_guard_next = arm_guard_reg;
        air_next       = air_reg;
        fwd            = 1'b0;
        lock           = 1'b0;
        throttle       = '0;
        mode           = MODE_MIX;

        if (item.usb_attached && item.usb_motor_test)
        begin
            ground_next = 1'b0;
            test_next   = 1'b1;
            ovr         = 1'b0;
        end
        else if (armed_reg && sw_test)
        begin
            test_next = 1'b1;
            ovr       = 1'b0;
        end
        else if (!item.turtle_active)
        begin
            test_next = 1'b0;
        end

        if (item.failsafe)
        begin
            fs_start_next = start_eff;
            lock          = elapsed > TIME_W'(cfg.lock_ms);
        end
        else
        begin
            fs_start_next = '0;
        end

        if (sw_arm && !lock)
        begin
            if (!prearm_reg && sw_prearm && !thr_over)
            begin
                arm_sw_next    = 1'b1;
                thr_guard_next = 1'b0;
                fwd            = !item.reverse_pending;
            end
            else if (!arm_sw_reg)
            begin
                if (thr_over)
                    thr_guard_next = 1'b1;
                else
                    arm_guard_next = 1'b1;
            end
            prearm_next = 1'b1;
        end
        else
        begin
            arm_sw_next    = 1'b0;
            prearm_next    = 1'b0;
            thr_guard_next = 1'b0;
            if (item.rx_bound)
                arm_guard_next = 1'b0;
        end

        armed_next = arm_sw_next && !thr_guard_next && !arm_guard_next;

        if (!armed_next)
        begin
            air_next = 1'b0;
        end
        else
        begin
            if (!sw_idle)
            begin
                if (thr < QW'(DEAD_Q) || curved <= QW'(DEAD_Q))
                    throttle = '0;
                else
                    throttle = sat_q(gain_rnd);
            end
            else if (ovr)
            begin
                throttle = thr;
            end
            else
            begin
                throttle = sat_q(idle_sum);
            end
            if (thr_over)
                air_next = 1'b1;
        end

        if (test_next)
        begin
            mode = MODE_TEST;
        end
        else if (!armed_next || item.failsafe || throttle < QW'(OFF_Q))
        begin
            ground_next = 1'b1;
            throttle    = '0;
            mode        = MODE_OFF;
        end
        else
        begin
            ground_next = 1'b0;
            mode        = MODE_MIX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_start_reg  <= '0;
            prearm_reg    <= 1'b0;
            arm_sw_reg    <= 1'b0;
            thr_guard_reg <= 1'b0;
            arm_guard_reg <= 1'b1;
            armed_reg     <= 1'b0;
            air_reg       <= 1'b0;
            ground_reg    <= 1'b1;
            test_reg      <= 1'b0;
        end
        else if (step)
        begin
            fs_start_reg  <= fs_start_next;
            prearm_reg    <= prearm_next;
            arm_sw_reg    <= arm_sw_next;
            thr_guard_reg <= thr_guard_next;
            arm_guard_reg <= arm_guard_next;
            armed_reg     <= armed_next;
            air_reg       <= air_next;
            ground_reg    <= ground_next;
            test_reg      <= test_next;
        end
    end

    always_comb
    begin
        res.armed           = armed_next;
        res.airborne        = air_next;
        res.grounded        = ground_next;
        res.test_override   = test_next;
        res.override_active = ovr;
        res.throttle_out    = throttle;
        res.motor_mode      = mode;
        res.set_forward     = fwd;
        res.lockout         = lock;
        res.throttle_guard  = thr_guard_next;
        res.arm_guard       = arm_guard_next;
    end

endmodule

// ===== design/arming_failsafe_throttle_gate_unit.sv =====
// Top level of the arming / failsafe / throttle gate: input and result registers.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one control tick per transaction:
//   aux switches, link flags, millisecond time and raw and curved throttle.
//   Output channel (out_valid / out_stall) returns one result per tick: arming
//   flags, failsafe lockout, the mixer throttle in Q0.16 and the motor mode.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) set the
//   failsafe lock time, safety level and idle level; cfg_ready is always high.
//   Write configuration only while no tick is in flight.
// Timing:
//   A tick is registered on input, evaluated by flag logic and a single 16x17
//   multiply, and lands in the result register: out_valid rises once both the input
//   and the result register have taken it. One tick per cycle is sustained while out_stall is low.
// Reset:
//   rst_n clears both stages and restores the arming state (disarmed, on
//   ground, arming guard raised) and the configuration defaults.
// Stall:
//   While out_stall holds a result, one further tick is still taken into the
//   input register; then in_stall rises until the result is taken.
module arming_failsafe_throttle_gate_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [3:0]                    aux_switches,
    input  logic                          failsafe,
    input  logic                          rx_bound,
    input  logic                          usb_attached,
    input  logic                          usb_motor_test,
    input  logic                          turtle_active,
    input  logic                          reverse_pending,
    input  logic                          override_request,
    input  logic [afg_pkg::TIME_W-1:0]    time_ms,
    input  logic [afg_pkg::QW-1:0]        stick_throttle,
    input  logic [afg_pkg::QW-1:0]        curved_throttle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          armed,
    output logic                          airborne,
    output logic                          grounded,
    output logic                          test_override,
    output logic                          override_active,
    output logic [afg_pkg::QW-1:0]        throttle_out,
    output logic [1:0]                    motor_mode,
    output logic                          set_forward,
    output logic                          lockout,
    output logic                          throttle_guard,
    output logic                          arm_guard,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [afg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [afg_pkg::CFG_W-1:0]     cfg_data
);
    import afg_pkg::*;

    cfg_t  cfg;
    item_t item_reg;
    item_t item_in;
    res_t  res_next;
    res_t  res_reg;
    logic  in_vld_reg;
    logic  out_vld_reg;
    logic  out_free;
    logic  step;
    logic  in_take;

    assign cfg_ready = 1'b1;

    afg_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_valid && cfg_ready),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    afg_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cfg   (cfg),
        .item  (item_reg),
        .res   (res_next)
    );

    assign out_free = !out_vld_reg || !out_stall;
    assign step     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_in.aux_switches     = aux_switches;
        item_in.failsafe         = failsafe;
        item_in.rx_bound         = rx_bound;
        item_in.usb_attached     = usb_attached;
        item_in.usb_motor_test   = usb_motor_test;
        item_in.turtle_active    = turtle_active;
        item_in.reverse_pending  = reverse_pending;
        item_in.override_request = override_request;
        item_in.time_ms          = time_ms;
        item_in.stick_throttle   = stick_throttle;
        item_in.curved_throttle  = curved_throttle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (step)
                in_vld_reg <= 1'b0;
            if (step)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= item_in;
        if (step)
            res_reg <= res_next;
    end

    assign out_valid       = out_vld_reg;
    assign armed           = res_reg.armed;
    assign airborne        = res_reg.airborne;
    assign grounded        = res_reg.grounded;
    assign test_override   = res_reg.test_override;
    assign override_active = res_reg.override_active;
    assign throttle_out    = res_reg.throttle_out;
    assign motor_mode      = res_reg.motor_mode;
    assign set_forward     = res_reg.set_forward;
    assign lockout         = res_reg.lockout;
    assign throttle_guard  = res_reg.throttle_guard;
    assign arm_guard       = res_reg.arm_guard;

    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motor_mode == MODE_OFF |-> throttle_out == '0)
        else $error("motors off with nonzero throttle");

    a_armed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && armed |-> !arm_guard && !throttle_guard)
        else $error("armed while a safety flag is raised");

    a_air_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && airborne |-> armed)
        else $error("airborne while disarmed");

    a_take_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_vld_reg)
        else $error("accepted transaction not held in input register");

endmodule
